// ----- sv/smrp_pkg.sv -----
// ============================================================================
// smrp_pkg - shared types and decode functions for the matrix record parser
// Phase codes, parser state, and the per-bit field extraction step.
// ============================================================================
package smrp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VAL_W     = 31;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned PH_W      = 4;
    localparam int unsigned RESULT_W  = 6 * VAL_W;
    localparam int unsigned M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [PH_W-1:0] PH_SCALE_FLAG  = 4'd0;
    localparam logic [PH_W-1:0] PH_SCALE_COUNT = 4'd1;
    localparam logic [PH_W-1:0] PH_SCALE_X     = 4'd2;
    localparam logic [PH_W-1:0] PH_SCALE_Y     = 4'd3;
    localparam logic [PH_W-1:0] PH_ROT_FLAG    = 4'd4;
    localparam logic [PH_W-1:0] PH_ROT_COUNT   = 4'd5;
    localparam logic [PH_W-1:0] PH_SKEW_A      = 4'd6;
    localparam logic [PH_W-1:0] PH_SKEW_B      = 4'd7;
    localparam logic [PH_W-1:0] PH_MOVE_COUNT  = 4'd8;
    localparam logic [PH_W-1:0] PH_MOVE_X      = 4'd9;
    localparam logic [PH_W-1:0] PH_MOVE_Y      = 4'd10;

    localparam logic [CNT_W-1:0] WIDTH_FLAG  = 5'd1;
    localparam logic [CNT_W-1:0] WIDTH_COUNT = 5'd5;

    // 1.0 in 15.16 (31-bit value, 16 fraction bits)
    localparam logic [VAL_W-1:0] ONE_16_16 = 31'd65536;

    typedef struct packed {
        logic [PH_W-1:0]  phase;
        logic [CNT_W-1:0] field_bits;
        logic [CNT_W-1:0] bits_rem;
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] scale_x;
        logic [VAL_W-1:0] scale_y;
        logic [VAL_W-1:0] skew_first;
        logic [VAL_W-1:0] skew_second;
        logic [VAL_W-1:0] move_x;
    } t_state;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] move_y;
        t_state           st;
    } t_step;

    typedef struct packed {
        logic signed [VAL_W-1:0] move_y;
        logic signed [VAL_W-1:0] move_x;
        logic signed [VAL_W-1:0] skew_second;
        logic signed [VAL_W-1:0] skew_first;
        logic signed [VAL_W-1:0] scale_y;
        logic signed [VAL_W-1:0] scale_x;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_SCALE_FLAG,
        field_bits:  '0,
        bits_rem:    WIDTH_FLAG,
        acc:         '0,
        scale_x:     '0,
        scale_y:     '0,
        skew_first:  '0,
        skew_second: '0,
        move_x:      '0
    };

    function automatic t_state enter_phase(t_state s, logic [PH_W-1:0] p,
                                           logic [CNT_W-1:0] w);
        t_state r;
        r          = s;
        r.phase    = p;
        r.bits_rem = w;
        r.acc      = '0;
        return r;
    endfunction

    function automatic logic is_value_phase(logic [PH_W-1:0] p);
        return (p == PH_SCALE_X) || (p == PH_SCALE_Y) || (p == PH_SKEW_A) ||
               (p == PH_SKEW_B) || (p == PH_MOVE_X) || (p == PH_MOVE_Y);
    endfunction

    // A zero count skips straight past both values of its part, so every
    // transition leaves a nonzero field width or ends the record.
    function automatic t_step finish_field(t_state s, logic [VAL_W-1:0] v);
        t_step r;
        r.done   = 1'b0;
        r.move_y = '0;
        r.st     = s;
        unique case (s.phase)
            PH_SCALE_COUNT: begin
                r.st.field_bits = v[CNT_W-1:0];
                if (v[CNT_W-1:0] == '0) begin
                    r.st.scale_x = '0;
                    r.st.scale_y = '0;
                    r.st = enter_phase(r.st, PH_ROT_FLAG, WIDTH_FLAG);
                end else begin
                    r.st = enter_phase(r.st, PH_SCALE_X, v[CNT_W-1:0]);
                end
            end
            PH_SCALE_X: begin
                r.st.scale_x = v;
                r.st = enter_phase(r.st, PH_SCALE_Y, s.field_bits);
            end
            PH_SCALE_Y: begin
                r.st.scale_y = v;
                r.st = enter_phase(r.st, PH_ROT_FLAG, WIDTH_FLAG);
            end
            PH_ROT_FLAG: begin
                if (v[0]) begin
                    r.st = enter_phase(r.st, PH_ROT_COUNT, WIDTH_COUNT);
                end else begin
                    r.st.skew_first  = '0;
                    r.st.skew_second = '0;
                    r.st = enter_phase(r.st, PH_MOVE_COUNT, WIDTH_COUNT);
                end
            end
            PH_ROT_COUNT: begin
                r.st.field_bits = v[CNT_W-1:0];
                if (v[CNT_W-1:0] == '0) begin
                    r.st.skew_first  = '0;
                    r.st.skew_second = '0;
                    r.st = enter_phase(r.st, PH_MOVE_COUNT, WIDTH_COUNT);
                end else begin
                    r.st = enter_phase(r.st, PH_SKEW_A, v[CNT_W-1:0]);
                end
            end
            PH_SKEW_A: begin
                r.st.skew_first = v;
                r.st = enter_phase(r.st, PH_SKEW_B, s.field_bits);
            end
            PH_SKEW_B: begin
                r.st.skew_second = v;
                r.st = enter_phase(r.st, PH_MOVE_COUNT, WIDTH_COUNT);
            end
            PH_MOVE_COUNT: begin
                r.st.field_bits = v[CNT_W-1:0];
                if (v[CNT_W-1:0] == '0) begin
                    r.st.move_x = '0;
                    r.move_y    = '0;
                    r.done      = 1'b1;
                    r.st = enter_phase(r.st, PH_SCALE_FLAG, WIDTH_FLAG);
                end else begin
                    r.st = enter_phase(r.st, PH_MOVE_X, v[CNT_W-1:0]);
                end
            end
            PH_MOVE_X: begin
                r.st.move_x = v;
                r.st = enter_phase(r.st, PH_MOVE_Y, s.field_bits);
            end
            PH_MOVE_Y: begin
                r.move_y = v;
                r.done   = 1'b1;
                r.st = enter_phase(r.st, PH_SCALE_FLAG, WIDTH_FLAG);
            end
            default: begin
                // scale flag
                if (v[0]) begin
                    r.st = enter_phase(r.st, PH_SCALE_COUNT, WIDTH_COUNT);
                end else begin
                    r.st.scale_x = ONE_16_16;
                    r.st.scale_y = ONE_16_16;
                    r.st = enter_phase(r.st, PH_ROT_FLAG, WIDTH_FLAG);
                end
            end
        endcase
        return r;
    endfunction

    // The first bit of a value fills the whole accumulator, so the value
    // comes out already sign-extended when its last bit arrives.
    function automatic t_step bit_step(t_state s, logic b);
        t_step r;
        r.done   = 1'b0;
        r.move_y = '0;
        r.st     = s;
        if (is_value_phase(s.phase) && (s.bits_rem == s.field_bits)) begin
            r.st.acc = {VAL_W{b}};
        end else begin
            r.st.acc = {s.acc[VAL_W-2:0], b};
        end
        if (s.bits_rem != '0) begin
            r.st.bits_rem = s.bits_rem - 1'b1;
        end
        if (r.st.bits_rem == '0) begin
            r = finish_field(r.st, r.st.acc);
        end
        return r;
    endfunction

endpackage

// ----- sv/smrp_decode.sv -----
// ============================================================================
// smrp_decode - one-byte field extractor
// Runs the eight bit steps of one byte against the parser state and reports
// the next state and whether a record completed in this byte.
// ============================================================================
module smrp_decode (
    input  smrp_pkg::t_state              i_state,
    input  logic [smrp_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_start,
    output smrp_pkg::t_state              o_state,
    output logic                          o_emit,
    output smrp_pkg::t_result             o_result
);

    always_comb begin
        smrp_pkg::t_state            s;
        smrp_pkg::t_step             r;
        logic                        done;
        logic [smrp_pkg::VAL_W-1:0]  my;
        s = i_state;
        r = '0;
        if (i_start) begin
            s = smrp_pkg::enter_phase(s, smrp_pkg::PH_SCALE_FLAG, smrp_pkg::WIDTH_FLAG);
        end
        done = 1'b0;
        my   = '0;
        // MSB first; bits after a completed record are dropped
        for (int i = smrp_pkg::BYTE_W - 1; i >= 0; i--) begin
            if (!done) begin
                r    = smrp_pkg::bit_step(s, i_byte[i]);
                s    = r.st;
                done = r.done;
                my   = r.move_y;
            end
        end
        o_state              = s;
        o_emit               = done;
        o_result.scale_x     = s.scale_x;
        o_result.scale_y     = s.scale_y;
        o_result.skew_first  = s.skew_first;
        o_result.skew_second = s.skew_second;
        o_result.move_x      = s.move_x;
        o_result.move_y      = my;
    end

endmodule

// ----- sv/smrp_out_reg.sv -----
// ============================================================================
// smrp_out_reg - result register
// Holds one decoded matrix until the downstream side takes it.
// ============================================================================
module smrp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  smrp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output smrp_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    smrp_pkg::t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- sv/swf_matrix_record_parser.sv -----
// ============================================================================
// swf_matrix_record_parser - compressed 2x3 matrix record decoder
// Consumes a byte stream and emits one decoded matrix per completed record.
// ============================================================================
// Usage:
//  Slave channel: one stream byte per transaction in tdata[7:0]; tuser high
//  restarts parsing with this byte as the first byte of a new record.
//  Master channel: one transaction per completed record carrying scale_x,
//  scale_y, skew_first, skew_second, move_x and move_y, 31-bit two's
//  complement each. Bytes that finish no record produce nothing.
//  A byte is held in the input register, its result in the result register.
//  Throughput is one byte per cycle unless stalled; the limit is the
//  eight-bit unrolled field extractor feeding the parser state register.
//  Stall: while a result waits, bytes that complete no record still flow;
//  a byte that completes a record waits in the input register until the
//  waiting result is taken, and tready drops only then.
//  Reset: parser returns to the scale flag of a fresh record, held values
//  are cleared and both channels are empty.
// ============================================================================
module swf_matrix_record_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [smrp_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // data_byte
    input  logic                             i_s_axis_tuser,  // record_start
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // scale_x, scale_y, skew_first, skew_second, move_x, move_y, zero pad
    output logic [smrp_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    logic                          r_in_valid;
    logic [smrp_pkg::BYTE_W-1:0]   r_in_byte;
    logic                          r_in_start;
    smrp_pkg::t_state              r_state;

    smrp_pkg::t_state              w_next_state;
    logic                          w_emit;
    smrp_pkg::t_result             w_result;
    smrp_pkg::t_result             w_out_result;
    logic                          w_out_valid;
    logic                          w_fire;

    smrp_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_state  (w_next_state),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // a byte that yields no record never waits on the output side
    assign w_fire = r_in_valid && (!w_emit || !w_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= smrp_pkg::STATE_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_fire) begin
                r_state <= w_next_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
    end

    smrp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_emit),
        .i_result (w_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (w_out_valid),
        .o_result (w_out_result)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = {
        {(smrp_pkg::M_TDATA_W - smrp_pkg::RESULT_W){1'b0}},
        w_out_result
    };

endmodule
